// File: rtl/core/pipw_pkg.sv
// Shared constants and types for the quadrant-winding point-in-polygon block.
package pipw_pkg;

    localparam int MAX_V   = 32;
    localparam int CW      = 32;
    localparam int ADDR_W  = (MAX_V > 1) ? $clog2(MAX_V) : 1;
    localparam int CNT_W   = $clog2(MAX_V + 1);
    localparam int SLOT_W  = 5;
    localparam int VCNT_W  = 6;
    localparam int TOT_W   = 8;
    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(4);

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_QUERY = 1'b1;

    // quadrant step codes
    localparam logic signed [3:0] STEP_P3 = 4'sd3;
    localparam logic signed [3:0] STEP_M3 = -4'sd3;
    localparam logic signed [3:0] STEP_P2 = 4'sd2;
    localparam logic signed [3:0] STEP_M2 = -4'sd2;
    localparam logic signed [3:0] STEP_P1 = 4'sd1;
    localparam logic signed [3:0] STEP_M1 = -4'sd1;

    localparam logic signed [TOT_W-1:0] INSIDE_TOT = TOT_W'(4);

    typedef struct packed {
        logic                   is_query;
        logic                   wr_ok;
        logic [SLOT_W-1:0]      slot;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
    } pipw_item_t;

endpackage

// File: rtl/core/pipw_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
module pipw_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [pipw_pkg::SLOT_W-1:0] vertex_slot,
    input  logic signed [31:0]          point_x,
    input  logic signed [31:0]          point_y,
    output logic                        q_valid,
    output pipw_pkg::pipw_item_t        q_item,
    input  logic                        q_pop
);

    pipw_pkg::pipw_item_t entry_reg [2];
    pipw_pkg::pipw_item_t new_item;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    always_comb
    begin
        new_item.is_query = (mode == pipw_pkg::MODE_QUERY);
        new_item.wr_ok    = (int'(vertex_slot) < pipw_pkg::MAX_V);
        new_item.slot     = vertex_slot;
        new_item.x        = point_x[pipw_pkg::CW-1:0];
        new_item.y        = point_y[pipw_pkg::CW-1:0];
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/pipw_back.sv
// Back end: vertex store, pipelined edge walker and result register.
module pipw_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pipw_pkg::VCNT_W-1:0]     vcount,
    input  logic                            q_valid,
    input  pipw_pkg::pipw_item_t            q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            inside_res,
    output logic signed [pipw_pkg::TOT_W-1:0] winding_total
);

    localparam int CW = pipw_pkg::CW;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DONE} state_t;

    function automatic logic gt_sm(input logic na, input logic [2*CW-1:0] ma,
                                   input logic nb, input logic [2*CW-1:0] mb);
        logic r;
        if (na != nb)
            r = nb;
        else if (!na)
            r = (ma > mb);
        else
            r = (ma < mb);
        return r;
    endfunction

    logic [2*CW-1:0] mem [pipw_pkg::MAX_V];
    logic [2*CW-1:0] rd_data_reg;

    state_t state_reg;
    logic [pipw_pkg::CNT_W-1:0]  cnt_reg;
    logic [pipw_pkg::CNT_W-1:0]  n_eff;
    logic [pipw_pkg::ADDR_W-1:0] rd_addr;
    logic signed [CW-1:0] px_reg, py_reg;

    // stage 1: read data arriving
    logic s1_v_reg, s1_first_reg, s1_last_reg;
    logic signed [CW-1:0] x0_reg, y0_reg;
    logic [2:0] q_reg;

    // stage 2: magnitudes and signs
    logic s2_v_reg, s2_last_reg;
    logic signed [3:0] s2_dl_reg;
    logic s2_is2_reg, s2_dpos_reg;
    logic s2_sa_reg, s2_sd_reg, s2_sb_reg, s2_sc_reg;
    logic [CW-1:0] s2_ma_reg, s2_md_reg, s2_mb_reg, s2_mc_reg;

    // stage 3: products
    logic s3_v_reg, s3_last_reg;
    logic signed [3:0] s3_dl_reg;
    logic s3_is2_reg, s3_dpos_reg, s3_sl_reg, s3_sr_reg;
    logic [2*CW-1:0] s3_ml_reg, s3_mr_reg;

    logic signed [pipw_pkg::TOT_W-1:0] acc_reg;
    logic out_valid_reg, inside_reg;
    logic signed [pipw_pkg::TOT_W-1:0] total_reg;

    // stage 1 combinational
    logic signed [CW-1:0] x1, y1;
    logic [2:0] nq;
    logic signed [3:0] delta, dl;
    logic is2;
    logic signed [CW:0] da, dd, db, dc;
    // stage 3 combinational
    logic nl, nr, right;
    logic signed [3:0] step;

    always_comb
    begin
        if (int'(vcount) > pipw_pkg::MAX_V)
            n_eff = pipw_pkg::CNT_W'(pipw_pkg::MAX_V);
        else if (vcount == '0)
            n_eff = pipw_pkg::CNT_W'(1);
        else
            n_eff = pipw_pkg::CNT_W'(vcount);
    end

    assign rd_addr = (cnt_reg == n_eff) ? '0 : cnt_reg[pipw_pkg::ADDR_W-1:0];
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_item.is_query && q_item.wr_ok)
        begin
            mem[pipw_pkg::ADDR_W'(q_item.slot)] <= {q_item.y, q_item.x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        x1 = rd_data_reg[CW-1:0];
        y1 = rd_data_reg[2*CW-1:CW];
        if (x1 > px_reg)
            nq = (y1 > py_reg) ? 3'd1 : 3'd4;
        else
            nq = (y1 > py_reg) ? 3'd2 : 3'd3;
        delta = signed'({1'b0, nq}) - signed'({1'b0, q_reg});
        is2   = 1'b0;
        if (delta == pipw_pkg::STEP_P3)
            dl = pipw_pkg::STEP_M1;
        else if (delta == pipw_pkg::STEP_M3)
            dl = pipw_pkg::STEP_P1;
        else
        begin
            dl  = delta;
            is2 = (delta == pipw_pkg::STEP_P2) || (delta == pipw_pkg::STEP_M2);
        end
        da = (CW+1)'(x1) - (CW+1)'(px_reg);
        dd = (CW+1)'(y0_reg) - (CW+1)'(y1);
        db = (CW+1)'(y1) - (CW+1)'(py_reg);
        dc = (CW+1)'(x0_reg) - (CW+1)'(x1);
    end

    always_comb
    begin
        nl    = (s3_ml_reg != '0) && s3_sl_reg;
        nr    = (s3_mr_reg != '0) && s3_sr_reg;
        right = s3_dpos_reg ? gt_sm(nl, s3_ml_reg, nr, s3_mr_reg)
                            : gt_sm(nr, s3_mr_reg, nl, s3_ml_reg);
        step  = (s3_is2_reg && right) ? -s3_dl_reg : s3_dl_reg;
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.is_query)
        begin
            px_reg <= q_item.x;
            py_reg <= q_item.y;
        end
        if (s1_v_reg)
        begin
            x0_reg <= x1;
            y0_reg <= y1;
            q_reg  <= nq;
        end
        s2_dl_reg   <= dl;
        s2_is2_reg  <= is2;
        s2_dpos_reg <= !dd[CW] && (dd != '0);
        s2_sa_reg   <= da[CW];
        s2_sd_reg   <= dd[CW];
        s2_sb_reg   <= db[CW];
        s2_sc_reg   <= dc[CW];
        s2_ma_reg   <= da[CW] ? CW'(-da) : CW'(da);
        s2_md_reg   <= dd[CW] ? CW'(-dd) : CW'(dd);
        s2_mb_reg   <= db[CW] ? CW'(-db) : CW'(db);
        s2_mc_reg   <= dc[CW] ? CW'(-dc) : CW'(dc);
        s3_dl_reg   <= s2_dl_reg;
        s3_is2_reg  <= s2_is2_reg;
        s3_dpos_reg <= s2_dpos_reg;
        s3_sl_reg   <= s2_sa_reg ^ s2_sd_reg;
        s3_sr_reg   <= s2_sb_reg ^ s2_sc_reg;
        s3_ml_reg   <= s2_ma_reg * s2_md_reg;
        s3_mr_reg   <= s2_mb_reg * s2_mc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            s1_v_reg      <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_v_reg      <= 1'b0;
            s2_last_reg   <= 1'b0;
            s3_v_reg      <= 1'b0;
            s3_last_reg   <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            s1_v_reg     <= (state_reg == ST_WALK);
            s1_first_reg <= (cnt_reg == '0);
            s1_last_reg  <= (cnt_reg == n_eff);
            s2_v_reg     <= s1_v_reg && !s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s3_v_reg     <= s2_v_reg;
            s3_last_reg  <= s2_last_reg;

            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop && q_item.is_query)
                    begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    cnt_reg <= cnt_reg + pipw_pkg::CNT_W'(1);
                    if (cnt_reg == n_eff)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (s3_v_reg)
                    begin
                        acc_reg <= acc_reg + pipw_pkg::TOT_W'(step);
                        if (s3_last_reg)
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        total_reg     <= acc_reg;
                        inside_reg    <= (acc_reg == pipw_pkg::INSIDE_TOT)
                                      || (acc_reg == -pipw_pkg::INSIDE_TOT);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // edges that reach the last stage while the walk counter is still running
            if (state_reg == ST_WALK && s3_v_reg)
            begin
                acc_reg <= acc_reg + pipw_pkg::TOT_W'(step);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign inside_res    = inside_reg;
    assign winding_total = total_reg;

endmodule

// File: rtl/core/point_in_polygon_winding.sv
// Quadrant-winding point-in-polygon test: holds up to 32 vertices and answers
// point queries. A vertex write leaves the queue while the back end is idle. A query
// walks vertex_count edges (0 is taken as 1, above 32 as 32) one per cycle through
// a single read port of the vertex store, then a four-stage edge pipeline
// (read, differences, two 32x32 products, exact intercept compare and sum)
// and then into the result register; the back end can take its next item in the
// cycle in which the result appears. A two-entry queue in front takes new items
// while a query is being walked, and the result register holds a finished result
// until it is taken.
module point_in_polygon_winding (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pipw_pkg::VCNT_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [pipw_pkg::SLOT_W-1:0]      vertex_slot,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             inside_res,
    output logic signed [pipw_pkg::TOT_W-1:0] winding_total
);

    logic [pipw_pkg::VCNT_W-1:0] vcount_reg;
    logic                 q_valid;
    logic                 q_pop;
    pipw_pkg::pipw_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= pipw_pkg::VCNT_RESET;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_data;
        end
    end

    pipw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .vertex_slot (vertex_slot),
        .point_x     (point_x),
        .point_y     (point_y),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    pipw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .vcount        (vcount_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .inside_res    (inside_res),
        .winding_total (winding_total)
    );

endmodule

// File: rtl/core/pipw_checker.sv
// Port-level checks for the point-in-polygon block, bound to the top level.
module pipw_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               inside_res,
    input logic signed [pipw_pkg::TOT_W-1:0]  winding_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(winding_total))
        else $error("stalled result dropped or changed");

    a_inside_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inside_res == ((winding_total == 8'sd4) ||
                                     (winding_total == -8'sd4)))
        else $error("inside flag disagrees with total");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (winding_total <= 8'sd64) && (winding_total >= -8'sd64))
        else $error("winding total out of range");

    a_inside_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(inside_res))
        else $error("stalled inside flag changed");

endmodule

bind point_in_polygon_winding pipw_checker u_pipw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .inside_res    (inside_res),
    .winding_total (winding_total)
);
